FILE: hw/rtl/rse_pkg.sv
package rse_pkg;

  // table geometry
  localparam int CLUSTERS    = 16;
  localparam int ALPHABET    = 64;
  localparam int TABLE_DEPTH = CLUSTERS * ALPHABET;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // field widths
  localparam int REQ_W   = 2;
  localparam int CL_W    = 4;
  localparam int SYM_W   = 6;
  localparam int FREQ_W  = 13;
  localparam int START_W = 12;
  localparam int DATA_W  = 8;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 5;
  localparam int ENTRY_W = FREQ_W + START_W;

  // coder arithmetic
  localparam int STATE_W      = 30;
  localparam int PREC_BITS    = 12;
  localparam int RENORM_SHIFT = 18;
  localparam int QUOT_W       = RENORM_SHIFT;
  localparam int REM_W        = FREQ_W;
  localparam int LIMIT_W      = STATE_W + 1;
  localparam int FLUSH_BYTES  = 4;
  localparam int STEP_W       = $clog2(QUOT_W);

  localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1 << 22);
  localparam logic [FREQ_W-1:0]  PREC_TOTAL  = FREQ_W'(1 << PREC_BITS);

  // queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CLUSTER = 2'd1,
    ST_ZERO_FREQ   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD        = 2'd0,
    CMD_ENCODE      = 2'd1,
    CMD_FLUSH       = 2'd2,
    CMD_BAD_CLUSTER = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                sym_ok;
    logic [IDX_W-1:0]    idx;
    logic [FREQ_W-1:0]   freq;
    logic [START_W-1:0]  start;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_if_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_push_t;

endpackage

FILE: hw/rtl/rse_ram.sv
module rse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rse_front.sv
module rse_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [rse_pkg::REQ_W-1:0]    req_type,
  input  logic [rse_pkg::CL_W-1:0]     cluster,
  input  logic [rse_pkg::SYM_W-1:0]    symbol,
  input  logic [rse_pkg::FREQ_W-1:0]   load_freq,
  input  logic [rse_pkg::START_W-1:0]  load_start,
  input  logic                         cfg_we,
  input  logic [rse_pkg::CFG_W-1:0]    cfg_wdata,
  input  rse_pkg::back_ctl_t           back_ctl,
  output rse_pkg::cmd_if_t             cmd_out
);

  logic [rse_pkg::CFG_W-1:0]      active_clusters;
  rse_pkg::cmd_t                  q [rse_pkg::CMDQ_DEPTH];
  logic [rse_pkg::CMDQ_PTR_W-1:0] wptr, rptr;
  logic [rse_pkg::CMDQ_CNT_W-1:0] count, count_next;

  rse_pkg::req_t  req;
  rse_pkg::cmd_t  cmd_new;
  logic           accept, enq, cl_in_range, sym_in_range, cl_active;

  assign full   = (count == rse_pkg::CMDQ_CNT_W'(rse_pkg::CMDQ_DEPTH)) || back_ctl.clearing;
  assign accept = push && !full;
  assign req    = rse_pkg::req_t'(req_type);

  assign cl_in_range  = int'(cluster) < rse_pkg::CLUSTERS;
  assign sym_in_range = int'(symbol) < rse_pkg::ALPHABET;
  assign cl_active    = ({1'b0, cluster} < active_clusters) && cl_in_range;

  // classify the item into a command for the back end
  always_comb begin
    cmd_new.sym_ok = sym_in_range;
    cmd_new.idx    = rse_pkg::IDX_W'(int'(cluster) * rse_pkg::ALPHABET + int'(symbol));
    cmd_new.freq   = (load_freq > rse_pkg::PREC_TOTAL) ? rse_pkg::PREC_TOTAL : load_freq;
    cmd_new.start  = load_start;
    enq            = 1'b0;
    unique case (req)
      rse_pkg::REQ_LOAD: begin
        cmd_new.kind = rse_pkg::CMD_LOAD;
        enq          = accept && cl_in_range && sym_in_range;
      end
      rse_pkg::REQ_ENCODE: begin
        cmd_new.kind = cl_active ? rse_pkg::CMD_ENCODE : rse_pkg::CMD_BAD_CLUSTER;
        enq          = accept;
      end
      rse_pkg::REQ_FLUSH: begin
        cmd_new.kind = rse_pkg::CMD_FLUSH;
        enq          = accept;
      end
      rse_pkg::REQ_RSVD: begin
        cmd_new.kind = rse_pkg::CMD_LOAD;
      end
      default: begin
        cmd_new.kind = rse_pkg::CMD_LOAD;
      end
    endcase
  end

  assign count_next = count + rse_pkg::CMDQ_CNT_W'(enq) - rse_pkg::CMDQ_CNT_W'(back_ctl.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_clusters <= '0;
      wptr            <= '0;
      rptr            <= '0;
      count           <= '0;
    end else begin
      if (cfg_we) begin
        active_clusters <= cfg_wdata;
      end
      if (enq) begin
        wptr <= wptr + 1'b1;
      end
      if (back_ctl.pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wptr] <= cmd_new;
    end
  end

  assign cmd_out.valid = (count != '0);
  assign cmd_out.cmd   = q[rptr];

endmodule

FILE: hw/rtl/rse_outq.sv
module rse_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  rse_pkg::res_push_t          res_in,
  output logic                        outq_full,
  output logic                        empty,
  input  logic                        pop,
  output logic [rse_pkg::DATA_W-1:0]  out_byte,
  output logic [rse_pkg::ST_W-1:0]    status,
  output logic                        last
);

  rse_pkg::result_t               q [rse_pkg::OUTQ_DEPTH];
  logic [rse_pkg::OUTQ_PTR_W-1:0] wptr, rptr;
  logic [rse_pkg::OUTQ_CNT_W-1:0] count;
  logic                           wr, rd;

  assign outq_full = (count == rse_pkg::OUTQ_CNT_W'(rse_pkg::OUTQ_DEPTH));
  assign empty     = (count == '0);
  assign wr        = res_in.push && !outq_full;
  assign rd        = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + rse_pkg::OUTQ_CNT_W'(wr) - rse_pkg::OUTQ_CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wptr] <= res_in.res;
    end
  end

  assign out_byte = q[rptr].data;
  assign status   = rse_pkg::ST_W'(q[rptr].status);
  assign last     = q[rptr].last;

endmodule

FILE: hw/rtl/rse_back.sv
module rse_back (
  input  logic                clk,
  input  logic                rst,
  input  rse_pkg::cmd_if_t    cmd_in,
  output rse_pkg::back_ctl_t  ctl,
  input  logic                outq_full,
  output rse_pkg::res_push_t  res
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOOK   = 7'b0000100,
    S_RENORM = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t                           state, state_next;
  logic [rse_pkg::IDX_W-1:0]        clr_addr;
  logic [rse_pkg::STATE_W-1:0]      coder_state;
  logic [rse_pkg::STATE_W-1:0]      x;
  logic [1:0]                       nbytes;
  logic                             sym_ok;
  logic [rse_pkg::REM_W-1:0]        rem;
  logic [rse_pkg::QUOT_W-1:0]       quo;
  logic [rse_pkg::STEP_W-1:0]       step;
  logic [1:0]                       fbyte;

  logic                             ram_we, ram_re;
  logic [rse_pkg::IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [rse_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;

  logic [rse_pkg::FREQ_W-1:0]       freq;
  logic [rse_pkg::START_W-1:0]      start;
  logic [rse_pkg::LIMIT_W-1:0]      limit;
  logic                             ge_now, ge_next, emit;
  logic [rse_pkg::REM_W:0]          trial, diff;
  logic                             qbit;
  logic [31:0]                      state_pad;
  logic [rse_pkg::DATA_W-1:0]       flush_data;

  rse_ram #(
    .WIDTH (rse_pkg::ENTRY_W),
    .DEPTH (rse_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read data holds until the next lookup
  assign freq  = ram_rdata[rse_pkg::ENTRY_W-1 -: rse_pkg::FREQ_W];
  assign start = ram_rdata[rse_pkg::START_W-1:0];

  // renormalisation compares
  assign limit   = {freq, rse_pkg::RENORM_SHIFT'(0)};
  assign ge_now  = {1'b0, x} >= limit;
  assign ge_next = rse_pkg::LIMIT_W'(x >> 8) >= limit;
  assign emit    = ge_now && (nbytes != 2'd2);

  // one restoring division step
  assign trial = {rem, quo[rse_pkg::QUOT_W-1]};
  assign diff  = trial - {1'b0, freq};
  assign qbit  = trial >= {1'b0, freq};

  assign state_pad = 32'(coder_state);
  always_comb begin
    unique case (fbyte)
      2'd0:    flush_data = state_pad[31:24];
      2'd1:    flush_data = state_pad[23:16];
      2'd2:    flush_data = state_pad[15:8];
      2'd3:    flush_data = state_pad[7:0];
      default: flush_data = state_pad[7:0];
    endcase
  end

  always_comb begin
    state_next          = state;
    ram_we              = 1'b0;
    ram_waddr           = cmd_in.cmd.idx;
    ram_wdata           = {cmd_in.cmd.freq, cmd_in.cmd.start};
    ram_re              = 1'b0;
    ram_raddr           = cmd_in.cmd.idx;
    ctl.pop             = 1'b0;
    ctl.clearing        = 1'b0;
    res.push            = 1'b0;
    res.res.data        = '0;
    res.res.status      = rse_pkg::ST_OK;
    res.res.last        = 1'b1;
    unique case (state)
      S_CLEAR: begin
        ctl.clearing = 1'b1;
        ram_we       = 1'b1;
        ram_waddr    = clr_addr;
        ram_wdata    = '0;
        if (clr_addr == rse_pkg::IDX_W'(rse_pkg::TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_in.valid) begin
          unique case (cmd_in.cmd.kind)
            rse_pkg::CMD_LOAD: begin
              ram_we  = 1'b1;
              ctl.pop = 1'b1;
            end
            rse_pkg::CMD_ENCODE: begin
              ram_re     = 1'b1;
              ctl.pop    = 1'b1;
              state_next = S_LOOK;
            end
            rse_pkg::CMD_FLUSH: begin
              ctl.pop    = 1'b1;
              state_next = S_FLUSH;
            end
            rse_pkg::CMD_BAD_CLUSTER: begin
              res.res.status = rse_pkg::ST_BAD_CLUSTER;
              if (!outq_full) begin
                res.push = 1'b1;
                ctl.pop  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        if (!sym_ok || freq == '0) begin
          res.res.status = rse_pkg::ST_ZERO_FREQ;
          if (!outq_full) begin
            res.push   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_RENORM;
        end
      end
      S_RENORM: begin
        if (emit) begin
          res.res.data = x[rse_pkg::DATA_W-1:0];
          res.res.last = (nbytes == 2'd1) || !ge_next;
          res.push     = !outq_full;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == rse_pkg::STEP_W'(rse_pkg::QUOT_W - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        res.res.data = flush_data;
        res.res.last = (fbyte == 2'(rse_pkg::FLUSH_BYTES - 1));
        if (!outq_full) begin
          res.push = 1'b1;
          if (res.res.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      coder_state <= rse_pkg::LOWER_BOUND;
      fbyte       <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_FIN) begin
        coder_state <= rse_pkg::STATE_W'({quo, rse_pkg::PREC_BITS'(0)}
                       + rse_pkg::STATE_W'(rem) + rse_pkg::STATE_W'(start));
      end
      if (state == S_FLUSH && res.push) begin
        fbyte <= fbyte + 1'b1;
        if (res.res.last) begin
          coder_state <= rse_pkg::LOWER_BOUND;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sym_ok <= cmd_in.cmd.sym_ok;
    end
    if (state == S_LOOK) begin
      x      <= coder_state;
      nbytes <= '0;
    end
    if (state == S_RENORM) begin
      if (emit) begin
        if (!outq_full) begin
          x      <= x >> 8;
          nbytes <= nbytes + 1'b1;
        end
      end else begin
        rem  <= rse_pkg::REM_W'(x[rse_pkg::STATE_W-1:rse_pkg::RENORM_SHIFT]);
        quo  <= x[rse_pkg::QUOT_W-1:0];
        step <= '0;
      end
    end
    if (state == S_DIV) begin
      rem  <= qbit ? diff[rse_pkg::REM_W-1:0] : trial[rse_pkg::REM_W-1:0];
      quo  <= {quo[rse_pkg::QUOT_W-2:0], qbit};
      step <= step + 1'b1;
    end
  end

endmodule

FILE: hw/rtl/rans_static_encoder.sv
// a load goes through the command queue into the table from S_IDLE; an encode
// reads the table; S_RENORM pushes its bytes, S_IDLE or S_LOOK an error result
// an encode holds the back end through its 18-step divider
// flush: four bytes at one per cycle while the result queue has room
// reset: full stays high while all 1024 table entries are cleared, one per cycle
// reset also sets the coder state to 2^22 and active_clusters to 0
module rans_static_encoder (
  input  logic                         clk,
  input  logic                         rst,
  // input queue side
  input  logic                         push,
  output logic                         full,
  input  logic [rse_pkg::REQ_W-1:0]    req_type,
  input  logic [rse_pkg::CL_W-1:0]     cluster,
  input  logic [rse_pkg::SYM_W-1:0]    symbol,
  input  logic [rse_pkg::FREQ_W-1:0]   load_freq,
  input  logic [rse_pkg::START_W-1:0]  load_start,
  // result queue side
  output logic                         empty,
  input  logic                         pop,
  output logic [rse_pkg::DATA_W-1:0]   out_byte,
  output logic [rse_pkg::ST_W-1:0]     status,
  output logic                         last,
  // active_clusters register
  input  logic                         cfg_we,
  input  logic [rse_pkg::CFG_W-1:0]    cfg_wdata
);

  rse_pkg::cmd_if_t    cmd;
  rse_pkg::back_ctl_t  ctl;
  rse_pkg::res_push_t  res;
  logic                outq_full;

  // front end: takes each transfer, checks the cluster, queues a command for all but the unused request type
  rse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .cluster    (cluster),
    .symbol     (symbol),
    .load_freq  (load_freq),
    .load_start (load_start),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .back_ctl   (ctl),
    .cmd_out    (cmd)
  );

  // back end: table store, renormalisation, divider and flush sequencing
  rse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd),
    .ctl       (ctl),
    .outq_full (outq_full),
    .res       (res)
  );

  // result queue decouples the back end from the consumer
  rse_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_in    (res),
    .outq_full (outq_full),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

  // the clearing pass must hold off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input not held off during table clearing");

  // the back end never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.push |-> !outq_full)
    else $error("result pushed while result queue full");

  // an error result is always the only result of its item
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != rse_pkg::ST_OK) |-> last)
    else $error("error result without last");

  // commands are only taken from a non-empty command queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> cmd.valid)
    else $error("command popped from empty queue");

endmodule

FILE: tb/testbench.sv
module testbench;
  import rse_pkg::*;

  // quiet time after the last result before the register may change: covers
  // a full command queue of encodes that emit nothing plus one in the divider
  localparam int SETTLE_CYCLES = 100;
  // long receiver hold-off, long enough to back the block up to its input
  localparam int HOLD_CYCLES = 400;
  // cycles with no transfer on either side before the run is abandoned;
  // well above the table clearing pass and the long hold-off
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 23;
  localparam int PRESSURE_PHASE = 3;

  // how a directed row gets its expected results
  typedef enum logic [2:0] {
    BY_MODEL,
    NO_RESULT,
    BAD_CLUSTER_ERR,
    ZERO_FREQ_ERR,
    FRESH_FLUSH
  } typed_t;

  typedef struct {
    bit                   cfg_row;
    logic [CFG_W-1:0]     cfg_val;
    req_t                 rq;
    logic [CL_W-1:0]      cl;
    logic [SYM_W-1:0]     sym;
    logic [FREQ_W-1:0]    lf;
    logic [START_W-1:0]   ls;
    typed_t               how;
  } step_row_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [REQ_W-1:0]     req_type;
  logic [CL_W-1:0]      cluster;
  logic [SYM_W-1:0]     symbol;
  logic [FREQ_W-1:0]    load_freq;
  logic [START_W-1:0]   load_start;
  logic                 empty;
  logic                 pop;
  logic [DATA_W-1:0]    out_byte;
  logic [ST_W-1:0]      status;
  logic                 last;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;

  // coder mirror: state, tables and the active cluster count
  logic [STATE_W-1:0]   coder_x;
  logic [FREQ_W-1:0]    freq_tab [TABLE_DEPTH];
  logic [START_W-1:0]   start_tab [TABLE_DEPTH];
  logic [CFG_W-1:0]     active_cl;

  // bytes the mirror has produced for the item just taken, and the bytes
  // still owed by the block, oldest first
  result_t              fresh [$];
  result_t              coded_q [$];
  // table entries loaded with a nonzero frequency, as {cluster, symbol}
  int unsigned          live_entries [$];

  int unsigned mismatches, results_checked, error_results;
  int unsigned items_sent, loads_sent, encodes_sent, flushes_sent, settings_used;
  int          burst_left, hold_left, idle_cycles;
  bit          hold_request;

  // directed rows: extremes, every request type and the special cases; the
  // expected bytes are typed in where they are obvious, else left to the mirror
  step_row_t directed_steps [28] = '{
    // straight after reset no cluster is active
    '{0, 0,  REQ_ENCODE, 0,  0,  0,    0,    BAD_CLUSTER_ERR},
    '{0, 0,  REQ_FLUSH,  0,  0,  0,    0,    FRESH_FLUSH},
    // unused request type with every field bit set
    '{0, 0,  REQ_RSVD,   15, 63, 8191, 4095, NO_RESULT},
    '{1, 16, REQ_LOAD,   0,  0,  0,    0,    NO_RESULT},
    // cleared table entry
    '{0, 0,  REQ_ENCODE, 15, 63, 0,    0,    ZERO_FREQ_ERR},
    // frequency above 4096 saturates, encode emits nothing
    '{0, 0,  REQ_LOAD,   15, 63, 8191, 0,    NO_RESULT},
    '{0, 0,  REQ_ENCODE, 15, 63, 0,    0,    BY_MODEL},
    // smallest frequency: one renormalisation byte, then two
    '{0, 0,  REQ_LOAD,   0,  0,  1,    4095, NO_RESULT},
    '{0, 0,  REQ_ENCODE, 0,  0,  0,    0,    BY_MODEL},
    '{0, 0,  REQ_ENCODE, 0,  0,  0,    0,    BY_MODEL},
    // start plus frequency past 4096
    '{0, 0,  REQ_LOAD,   3,  5,  4095, 4095, NO_RESULT},
    '{0, 0,  REQ_ENCODE, 3,  5,  0,    0,    BY_MODEL},
    '{0, 0,  REQ_ENCODE, 3,  5,  0,    0,    BY_MODEL},
    // entry loaded with zero frequency
    '{0, 0,  REQ_LOAD,   1,  1,  0,    100,  NO_RESULT},
    '{0, 0,  REQ_ENCODE, 1,  1,  0,    0,    ZERO_FREQ_ERR},
    '{0, 0,  REQ_LOAD,   7,  9,  4096, 0,    NO_RESULT},
    '{0, 0,  REQ_ENCODE, 7,  9,  0,    0,    BY_MODEL},
    '{0, 0,  REQ_FLUSH,  0,  0,  0,    0,    BY_MODEL},
    '{1, 2,  REQ_LOAD,   0,  0,  0,    0,    NO_RESULT},
    '{0, 0,  REQ_ENCODE, 2,  0,  0,    0,    BAD_CLUSTER_ERR},
    '{0, 0,  REQ_ENCODE, 1,  1,  0,    0,    ZERO_FREQ_ERR},
    // no cluster active: loads still land, encodes are refused
    '{1, 0,  REQ_LOAD,   0,  0,  0,    0,    NO_RESULT},
    '{0, 0,  REQ_LOAD,   15, 0,  100,  200,  NO_RESULT},
    '{0, 0,  REQ_ENCODE, 0,  0,  0,    0,    BAD_CLUSTER_ERR},
    // register above the cluster count acts as all active
    '{1, 31, REQ_LOAD,   0,  0,  0,    0,    NO_RESULT},
    '{0, 0,  REQ_ENCODE, 15, 0,  0,    0,    BY_MODEL},
    '{0, 0,  REQ_FLUSH,  0,  0,  0,    0,    BY_MODEL},
    '{0, 0,  REQ_ENCODE, 15, 0,  0,    0,    BY_MODEL}
  };

  rans_static_encoder u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // rans mirror: applies one request to the coder copy and leaves the bytes
  // it owes in fresh
  function automatic void rans_apply(input req_t rq, input logic [CL_W-1:0] cl,
                                     input logic [SYM_W-1:0] sym,
                                     input logic [FREQ_W-1:0] lf,
                                     input logic [START_W-1:0] ls);
    int unsigned x, f, s, lim;
    int          n;
    logic [IDX_W-1:0] idx;
    idx = {cl, sym};
    n = 0;
    fresh.delete();
    case (rq)
      REQ_LOAD: begin
        freq_tab[idx] = (lf > PREC_TOTAL) ? PREC_TOTAL : lf;
        start_tab[idx] = ls;
      end
      REQ_ENCODE: begin
        f = freq_tab[idx];
        s = start_tab[idx];
        x = coder_x;
        lim = f << RENORM_SHIFT;
        if ({1'b0, cl} >= active_cl) begin
          fresh.push_back(result_t'{8'h00, ST_BAD_CLUSTER, 1'b1});
        end else if (f == 0) begin
          fresh.push_back(result_t'{8'h00, ST_ZERO_FREQ, 1'b1});
        end else begin
          // renormalise: low bytes out while the state is too large, two at most
          while (x >= lim && n < 2) begin
            fresh.push_back(result_t'{8'(x), ST_OK, ((x >> 8) < lim) || n == 1});
            x = x >> 8;
            n++;
          end
          coder_x = STATE_W'(((x / f) << PREC_BITS) + (x % f) + s);
        end
      end
      REQ_FLUSH: begin
        // high byte first
        for (int k = 3; k >= 0; k--)
          fresh.push_back(result_t'{8'(coder_x >> (8 * k)), ST_OK, k == 0});
        coder_x = LOWER_BOUND;
      end
      default: ;
    endcase
  endfunction

  // one input transfer: optional gap ahead of a new burst, then offer the
  // item until the block takes it, then book what it owes
  task automatic send_item(input req_t rq, input logic [CL_W-1:0] cl,
                           input logic [SYM_W-1:0] sym, input logic [FREQ_W-1:0] lf,
                           input logic [START_W-1:0] ls, input typed_t how);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    req_type <= rq;
    cluster <= cl;
    symbol <= sym;
    load_freq <= lf;
    load_start <= ls;
    @(posedge clk);
    while (full) @(posedge clk);
    rans_apply(rq, cl, sym, lf, ls);
    items_sent++;
    case (rq)
      REQ_LOAD:   loads_sent++;
      REQ_ENCODE: encodes_sent++;
      REQ_FLUSH:  flushes_sent++;
      default: ;
    endcase
    case (how)
      BY_MODEL: foreach (fresh[i]) coded_q.push_back(fresh[i]);
      BAD_CLUSTER_ERR: coded_q.push_back(result_t'{8'h00, ST_BAD_CLUSTER, 1'b1});
      ZERO_FREQ_ERR: coded_q.push_back(result_t'{8'h00, ST_ZERO_FREQ, 1'b1});
      FRESH_FLUSH: begin
        // state straight after reset is 2^22
        coded_q.push_back(result_t'{8'h00, ST_OK, 1'b0});
        coded_q.push_back(result_t'{8'h40, ST_OK, 1'b0});
        coded_q.push_back(result_t'{8'h00, ST_OK, 1'b0});
        coded_q.push_back(result_t'{8'h00, ST_OK, 1'b1});
      end
      default: ;
    endcase
  endtask

  // stop offering, wait for every owed byte, then let trailing work finish
  task automatic drain_and_settle();
    @(negedge clk);
    push <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [CFG_W-1:0] val);
    drain_and_settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_cl = val;
    settings_used++;
  endtask

  // random item: mostly table loads and encodes of loaded entries with random
  // content, the rest flushes, encodes of random entries and the unused request type
  task automatic random_item(input bit want_flush);
    int          p, tries;
    int unsigned idx;
    logic [CL_W-1:0]    cl;
    logic [SYM_W-1:0]   sym;
    logic [FREQ_W-1:0]  lf;
    logic [START_W-1:0] ls;
    req_t               rq;
    cl = $urandom_range(0, 15);
    sym = $urandom_range(0, 63);
    lf = $urandom_range(0, 8191);
    ls = $urandom_range(0, 4095);
    p = want_flush ? 82 : $urandom_range(0, 99);
    if (p < 25) begin
      rq = REQ_LOAD;
      cl = $urandom_range(0, (active_cl == 0 || active_cl > 16) ? 15 : active_cl - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: lf = $urandom_range(1, 64);
        4, 5, 6:    lf = $urandom_range(65, 4095);
        7:          lf = 4096;
        8:          lf = $urandom_range(4097, 8191);
        default:    lf = 0;
      endcase
      // mostly a consistent start, sometimes one that overruns 4096
      if (lf <= 4096 && $urandom_range(0, 3) != 0)
        ls = $urandom_range(0, (lf == 0) ? 4095 : 4096 - lf);
      if (lf != 0) live_entries.push_back({cl, sym});
    end else if (p < 80) begin
      rq = REQ_ENCODE;
      if (live_entries.size() != 0) begin
        tries = 0;
        do begin
          idx = live_entries[$urandom_range(0, live_entries.size() - 1)];
          tries++;
        end while (tries < 8 && ((idx >> SYM_W) >= active_cl || freq_tab[idx] == 0));
        cl = idx >> SYM_W;
        sym = idx;
      end
    end else if (p < 88) begin
      rq = REQ_FLUSH;
    end else if (p < 96) begin
      rq = REQ_ENCODE;
    end else begin
      rq = REQ_RSVD;
    end
    send_item(rq, cl, sym, lf, ls, BY_MODEL);
  endtask

  // result side: every popped transfer is matched against the oldest owed byte
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (coded_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h status %0d last %0b",
                         out_byte, status, last));
      end else begin
        want = coded_q.pop_front();
        results_checked++;
        if (want.status != ST_OK) error_results++;
        if (out_byte !== want.data || status !== want.status || last !== want.last)
          report($sformatf("got byte %02h status %0d last %0b, wanted %02h %0d %0b",
                           out_byte, status, last, want.data, want.status, want.last));
      end
    end
  end

  // receiver: segments of steady popping, sparse popping and stalls, plus
  // one long hold-off when the stimulus asks for it
  initial begin
    int mode, seg_left;
    pop = 1'b0;
    mode = 0;
    seg_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(4, 48);
        end
        seg_left--;
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 9) < 7);
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= 1'b0;
        endcase
      end
    end
  end

  // watchdog: any cycle with a transfer on either side restarts the count
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d bytes still owed",
               STALL_LIMIT, coded_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_cfg [PHASES];
    rst = 1'b1;
    push = 1'b0;
    req_type = REQ_LOAD;
    cluster = '0;
    symbol = '0;
    load_freq = '0;
    load_start = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_request = 1'b0;
    hold_left = 0;
    burst_left = 0;
    idle_cycles = 0;
    coder_x = LOWER_BOUND;
    active_cl = '0;
    foreach (freq_tab[i]) begin
      freq_tab[i] = '0;
      start_tab[i] = '0;
    end
    phase_cfg = '{16, 3, 1, 31, 0, 16};
    phase_cfg[4] = $urandom_range(0, 31);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; the first transfers also wait out the clearing pass
    foreach (directed_steps[i]) begin
      if (directed_steps[i].cfg_row)
        write_active(directed_steps[i].cfg_val);
      else
        send_item(directed_steps[i].rq, directed_steps[i].cl, directed_steps[i].sym,
                  directed_steps[i].lf, directed_steps[i].ls, directed_steps[i].how);
    end

    // random phases, each under its own cluster count; in the pressure phase
    // the receiver holds off while flushes arrive back to back
    for (int ph = 0; ph < PHASES; ph++) begin
      write_active(phase_cfg[ph]);
      if (ph == PRESSURE_PHASE) begin
        hold_request = 1'b1;
        burst_left = 60;
      end
      for (int k = 0; k < PHASE_ITEMS; k++)
        random_item(ph == PRESSURE_PHASE && k < 4);
    end

    drain_and_settle();
    while (coded_q.size() != 0) begin
      report("expected byte never arrived");
      void'(coded_q.pop_front());
    end

    $display("covered %0d items: %0d loads, %0d encodes, %0d flushes, %0d settings",
             items_sent, loads_sent, encodes_sent, flushes_sent, settings_used);
    $display("checked %0d results, %0d of them error codes, %0d mismatches",
             results_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
